// ===== src/rjlm_pkg.sv =====
package rjlm_pkg;

	localparam int unsigned REPORT_PERIOD   = 16;
	localparam int unsigned LOSS_STEP_LIMIT = 200;
	localparam int unsigned STEP_W          = $clog2(LOSS_STEP_LIMIT + 1);

	// Frame error rate scale: FER_FULL means 100 percent.
	localparam logic [18:0] FER_FULL = 19'd500000;

	// Reciprocals for division by 250 (shift 28) and by 5000 (shift 32).
	localparam logic [20:0] RECIP_250  = 21'd1073742;
	localparam logic [20:0] RECIP_5000 = 21'd858994;

	localparam logic [2:0] CFG_JITTER_LIMIT = 3'd0;
	localparam logic [2:0] CFG_LOSS_LIMIT   = 3'd1;
	localparam logic [2:0] CFG_REPORT_KIND  = 3'd2;
	localparam logic [2:0] CFG_INTERVAL     = 3'd3;
	localparam logic [2:0] CFG_REPORT_IVL   = 3'd4;

	localparam logic [1:0] OP_PACKET = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_CANCEL = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [1:0] MODE_TIME   = 2'd0;
	localparam logic [1:0] MODE_PACKET = 2'd1;

	localparam logic [2:0] RPT_PERIODIC = 3'd0;
	localparam logic [2:0] RPT_JITTER   = 3'd1;
	localparam logic [2:0] RPT_LOSS     = 3'd2;
	localparam logic [2:0] RPT_MODE_ERR = 3'd3;
	localparam logic [2:0] RPT_START    = 3'd4;

	typedef struct packed {
		logic        status;
		logic [2:0]  rtype;
		logic [27:0] jitter;
		logic [31:0] spurt;
		logic [47:0] transit;
		logic [27:0] bjitter;
		logic [6:0]  lpct;
		logic        last;
	} result_t;

endpackage

// ===== src/rjlm_recip_div.sv =====
module rjlm_recip_div (
	input  logic        clk,
	input  logic        go,
	input  logic        sel_5000,
	input  logic [18:0] x,
	output logic [11:0] q
);

	logic [39:0] prod_q;
	logic        sel_q;

	always_ff @(posedge clk) begin
		if (go) begin
			prod_q <= 40'(x) * 40'(sel_5000 ? rjlm_pkg::RECIP_5000 : rjlm_pkg::RECIP_250);
			sel_q  <= sel_5000;
		end
	end

	// Reciprocal error stays below one part in the remainder for x up to FER_FULL.
	assign q = sel_q ? {4'd0, prod_q[39:32]} : prod_q[39:28];

endmodule

// ===== src/rtp_jitter_loss_monitor_top.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_ready    op, arrival_ms, rtp_timestamp, marker, seq_num
// out      out_valid / out_ready  status, report_type, jitter_ms, spurt_packets,
//                                 transit_ms, breach_jitter_ms, loss_percent, last
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Start, cancel and clear requests go from idle through dispatch to flush. A packet passes
// dispatch, jitter update and periodic check, then flush when the checks are skipped, jitter
// check and wrap-up when only jitter is watched, plus loss stages when loss is watched (at
// most 200 frame error rate steps); the steps share one reciprocal multiplier.
// Reset clears the counters, estimates, configuration and valid flags; result and request registers are not reset.
// in_ready is low while a request is worked on; a stalled output holds the sequencer.
module rtp_jitter_loss_monitor_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [47:0]        arrival_ms,
	input  logic [31:0]        rtp_timestamp,
	input  logic               marker,
	input  logic [15:0]        seq_num,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic [2:0]         report_type,
	output logic [27:0]        jitter_ms,
	output logic [31:0]        spurt_packets,
	output logic signed [47:0] transit_ms,
	output logic [27:0]        breach_jitter_ms,
	output logic [6:0]         loss_percent,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_JIT   = 4'd2;
	localparam logic [3:0] S_PER   = 4'd3;
	localparam logic [3:0] S_JCHK  = 4'd4;
	localparam logic [3:0] S_LEXP  = 4'd5;
	localparam logic [3:0] S_LCASE = 4'd6;
	localparam logic [3:0] S_STEPA = 4'd7;
	localparam logic [3:0] S_STEPB = 4'd8;
	localparam logic [3:0] S_PCTA  = 4'd9;
	localparam logic [3:0] S_PCTB  = 4'd10;
	localparam logic [3:0] S_LCHK  = 4'd11;
	localparam logic [3:0] S_WRAP  = 4'd12;
	localparam logic [3:0] S_FLUSH = 4'd13;

	logic [3:0] state_q;

	logic [31:0] jitter_limit_q, report_ivl_q;
	logic [6:0]  loss_limit_q;
	logic [1:0]  report_kind_q, mode_q;

	logic [1:0]  op_q;
	logic [47:0] arrival_q;
	logic [31:0] ts_q;
	logic        marker_q;
	logic [15:0] seq_q;

	logic [31:0] spurt_q, jacc_q, recv_q, prev_exp_q, prev_recv_q, expected_q;
	logic [19:0] fer_q;
	logic [47:0] prev_transit_q, transit_q, wstart_q, last_arr_q;
	logic [15:0] cur_seq_q, base_seq_q;
	logic        jwatch_q, lwatch_q, watching_q;
	logic        do_loss_q, reached_q, sent_q, add_q, keep_q;
	logic [rjlm_pkg::STEP_W-1:0] count_q;
	logic [6:0]  pct_q;

	rjlm_pkg::result_t pend_q, out_q, emit_r;
	logic pend_valid_q, out_valid_q;
	logic emit_req, emit_ok, flush_req, out_free, adv;

	logic        div_go, div_sel;
	logic [18:0] div_x;
	logic [11:0] div_q;

	rjlm_recip_div u_div (
		.clk      (clk),
		.go       (div_go),
		.sel_5000 (div_sel),
		.x        (div_x),
		.q        (div_q)
	);

	// Packet arithmetic.
	logic [47:0] dtr, dabs;
	logic [28:0] jdecay;
	logic [48:0] nj;
	logic [48:0] elapsed;
	logic        reached_now, mode_bad;
	logic [31:0] exp_now, step_span;
	logic        c_steady, c_recover, c_gap;
	logic [rjlm_pkg::STEP_W-1:0] count_new;
	logic [19:0] fer_q20;

	assign dtr    = transit_q - prev_transit_q;
	assign dabs   = dtr[47] ? (48'd0 - dtr) : dtr;
	assign jdecay = 29'((33'(jacc_q) + 33'd8) >> 4);
	assign nj     = 49'(jacc_q) - 49'(jdecay) + 49'(dabs);

	assign elapsed  = {1'b0, last_arr_q} - {1'b0, wstart_q};
	assign mode_bad = mode_q[1];
	assign reached_now = (mode_q == rjlm_pkg::MODE_TIME) ?
		(!elapsed[48] && (49'(report_ivl_q) <= elapsed)) : (report_ivl_q == recv_q);

	assign exp_now   = {16'd0, cur_seq_q} - {16'd0, base_seq_q};
	assign c_steady  = (prev_exp_q - prev_recv_q) == (expected_q - recv_q);
	assign c_recover = (prev_recv_q < recv_q) && (prev_exp_q == expected_q);
	assign c_gap     = expected_q > prev_exp_q;
	assign step_span = expected_q - prev_exp_q - 32'd1;

	always_comb begin
		count_new = '0;
		if (c_steady || c_recover) begin
			count_new = rjlm_pkg::STEP_W'(1);
		end else if (c_gap) begin
			if (step_span > 32'(rjlm_pkg::LOSS_STEP_LIMIT)) begin
				count_new = rjlm_pkg::STEP_W'(rjlm_pkg::LOSS_STEP_LIMIT);
			end else begin
				count_new = step_span[rjlm_pkg::STEP_W-1:0];
			end
		end
	end

	assign fer_q20 = {8'd0, div_q};
	assign div_go  = (state_q == S_STEPA) || (state_q == S_PCTA);
	assign div_sel = (state_q == S_PCTA);
	assign div_x   = (state_q == S_STEPA && add_q) ? (rjlm_pkg::FER_FULL - fer_q[18:0])
		: fer_q[18:0];

	// Result requests from the sequencer.
	always_comb begin
		emit_req = 1'b0;
		emit_r = '0;
		emit_r.jitter  = jacc_q[31:4];
		emit_r.spurt   = spurt_q;
		emit_r.transit = prev_transit_q;
		unique case (state_q)
			S_DISP: begin
				if (op_q == rjlm_pkg::OP_START) begin
					emit_req = 1'b1;
					emit_r = '0;
					emit_r.rtype  = rjlm_pkg::RPT_START;
					emit_r.status = (report_kind_q == 2'd0);
				end
			end
			S_PER: begin
				emit_req = (spurt_q % rjlm_pkg::REPORT_PERIOD == 0) && (jacc_q != 32'd0);
				emit_r.rtype = rjlm_pkg::RPT_PERIODIC;
			end
			S_JCHK: begin
				if (jwatch_q) begin
					if (mode_bad) begin
						emit_req = 1'b1;
						emit_r.status = 1'b1;
						emit_r.rtype  = rjlm_pkg::RPT_MODE_ERR;
					end else if (reached_now && (jitter_limit_q < {4'd0, jacc_q[31:4]})) begin
						emit_req = 1'b1;
						emit_r.rtype   = rjlm_pkg::RPT_JITTER;
						emit_r.bjitter = jacc_q[31:4];
					end
				end
			end
			S_LCHK: begin
				if (mode_bad) begin
					emit_req = 1'b1;
					emit_r.status = 1'b1;
					emit_r.rtype  = rjlm_pkg::RPT_MODE_ERR;
				end else if (reached_now && (loss_limit_q < pct_q)) begin
					emit_req = 1'b1;
					emit_r.rtype = rjlm_pkg::RPT_LOSS;
					emit_r.lpct  = pct_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_free  = !out_valid_q || out_ready;
	assign emit_ok   = !pend_valid_q || out_free;
	assign adv       = !emit_req || emit_ok;
	assign flush_req = (state_q == S_FLUSH) && pend_valid_q;

	// The newest result is held back one place so that its last flag is known.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit_req && emit_ok) begin
				out_valid_q  <= pend_valid_q || (out_valid_q && !out_ready);
				pend_valid_q <= 1'b1;
			end else if (flush_req && out_free) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_req && emit_ok) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end
			pend_q <= emit_r;
		end else if (flush_req && out_free) begin
			out_q <= {pend_q[$bits(rjlm_pkg::result_t)-1:1], 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jitter_limit_q <= '0;
			loss_limit_q   <= '0;
			report_kind_q  <= '0;
			mode_q         <= '0;
			report_ivl_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rjlm_pkg::CFG_JITTER_LIMIT: jitter_limit_q <= cfg_data;
				rjlm_pkg::CFG_LOSS_LIMIT:   loss_limit_q   <= cfg_data[6:0];
				rjlm_pkg::CFG_REPORT_KIND:  report_kind_q  <= cfg_data[1:0];
				rjlm_pkg::CFG_INTERVAL:     mode_q         <= cfg_data[1:0];
				rjlm_pkg::CFG_REPORT_IVL:   report_ivl_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q      <= op;
			arrival_q <= arrival_ms;
			ts_q      <= rtp_timestamp;
			marker_q  <= marker;
			seq_q     <= seq_num;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			spurt_q        <= '0;
			jacc_q         <= '0;
			recv_q         <= '0;
			prev_exp_q     <= '0;
			prev_recv_q    <= '0;
			expected_q     <= '0;
			fer_q          <= '0;
			prev_transit_q <= '0;
			transit_q      <= '0;
			wstart_q       <= '0;
			last_arr_q     <= '0;
			cur_seq_q      <= '0;
			base_seq_q     <= '0;
			jwatch_q       <= 1'b0;
			lwatch_q       <= 1'b0;
			watching_q     <= 1'b0;
			do_loss_q      <= 1'b0;
			reached_q      <= 1'b0;
			sent_q         <= 1'b0;
			add_q          <= 1'b0;
			keep_q         <= 1'b0;
			count_q        <= '0;
			pct_q          <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					unique case (op_q)
						rjlm_pkg::OP_START: begin
							wstart_q <= arrival_q;
							if (report_kind_q[0]) jwatch_q <= 1'b1;
							if (report_kind_q[1]) lwatch_q <= 1'b1;
							if (report_kind_q != 2'd0) watching_q <= 1'b1;
							state_q <= S_FLUSH;
						end
						rjlm_pkg::OP_CANCEL: begin
							jwatch_q   <= 1'b0;
							lwatch_q   <= 1'b0;
							watching_q <= 1'b0;
							base_seq_q <= '0;
							state_q    <= S_FLUSH;
						end
						rjlm_pkg::OP_CLEAR: begin
							spurt_q        <= '0;
							jacc_q         <= '0;
							prev_transit_q <= '0;
							cur_seq_q      <= '0;
							base_seq_q     <= '0;
							recv_q         <= '0;
							state_q        <= S_FLUSH;
						end
						default: begin
							transit_q <= arrival_q - {19'd0, ts_q[31:3]};
							// A base re-taken at sequence zero skips the checks.
							do_loss_q <= !((mode_q == rjlm_pkg::MODE_PACKET || lwatch_q)
								&& seq_q == 16'd0);
							reached_q <= 1'b0;
							sent_q    <= 1'b0;
							if (mode_q == rjlm_pkg::MODE_PACKET || lwatch_q) begin
								cur_seq_q <= seq_q;
								if (base_seq_q == 16'd0 || base_seq_q > seq_q) begin
									if (seq_q != 16'd0) begin
										base_seq_q <= seq_q - 16'd1;
									end else begin
										base_seq_q <= '0;
									end
								end
								recv_q <= recv_q + 32'd1;
							end
							state_q <= S_JIT;
						end
					endcase
				end
				S_JIT: begin
					if (marker_q || spurt_q == 32'd0) begin
						jacc_q  <= '0;
						spurt_q <= 32'd1;
					end else begin
						jacc_q  <= nj[48:32] != 17'd0 ? 32'hFFFF_FFFF : nj[31:0];
						spurt_q <= spurt_q + 32'd1;
					end
					prev_transit_q <= transit_q;
					last_arr_q     <= arrival_q;
					state_q        <= S_PER;
				end
				S_PER: begin
					if (adv) begin
						state_q <= do_loss_q ? S_JCHK : S_FLUSH;
					end
				end
				S_JCHK: begin
					if (adv) begin
						if (jwatch_q) begin
							if (mode_bad) begin
								sent_q <= 1'b1;
							end else if (reached_now) begin
								reached_q <= 1'b1;
								if (emit_req) sent_q <= 1'b1;
							end
						end
						state_q <= lwatch_q ? S_LEXP : S_WRAP;
					end
				end
				S_LEXP: begin
					expected_q <= exp_now;
					state_q    <= S_LCASE;
				end
				S_LCASE: begin
					add_q       <= !c_steady;
					keep_q      <= !(!c_steady && c_recover);
					count_q     <= count_new;
					prev_exp_q  <= expected_q;
					prev_recv_q <= recv_q;
					state_q     <= (count_new == '0) ? S_PCTA : S_STEPA;
				end
				S_STEPA: begin
					state_q <= S_STEPB;
				end
				S_STEPB: begin
					if (add_q && keep_q) begin
						fer_q <= fer_q + fer_q20;
					end else if (keep_q) begin
						fer_q <= fer_q - fer_q20;
					end else begin
						fer_q <= (fer_q > fer_q20) ? (fer_q - fer_q20) : 20'd0;
					end
					count_q <= count_q - rjlm_pkg::STEP_W'(1);
					state_q <= (count_q == rjlm_pkg::STEP_W'(1)) ? S_PCTA : S_STEPA;
				end
				S_PCTA: begin
					state_q <= S_PCTB;
				end
				S_PCTB: begin
					pct_q   <= div_q[6:0];
					state_q <= S_LCHK;
				end
				S_LCHK: begin
					if (adv) begin
						if (mode_bad) begin
							sent_q <= 1'b1;
						end else if (reached_now) begin
							reached_q <= 1'b1;
							if (emit_req) sent_q <= 1'b1;
						end
						state_q <= S_WRAP;
					end
				end
				S_WRAP: begin
					if (reached_q) begin
						wstart_q <= arrival_q;
					end
					if (sent_q) begin
						jwatch_q   <= 1'b0;
						lwatch_q   <= 1'b0;
						watching_q <= 1'b0;
						base_seq_q <= '0;
					end
					state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					if (!pend_valid_q || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	assign out_valid        = out_valid_q;
	assign status           = out_q.status;
	assign report_type      = out_q.rtype;
	assign jitter_ms        = out_q.jitter;
	assign spurt_packets    = out_q.spurt;
	assign transit_ms       = out_q.transit;
	assign breach_jitter_ms = out_q.bjitter;
	assign loss_percent     = out_q.lpct;
	assign last             = out_q.last;

`ifndef SYNTHESIS
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_valid_q)
		else $error("held result left behind at end of request");
	a_fer_range: assert property (@(posedge clk) disable iff (!arst_n)
		fer_q <= {1'b0, rjlm_pkg::FER_FULL})
		else $error("frame error rate out of range");
	a_step_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEPA || state_q == S_STEPB) |->
		(count_q != '0 && count_q <= rjlm_pkg::STEP_W'(rjlm_pkg::LOSS_STEP_LIMIT)))
		else $error("loss step count out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_q))
		else $error("stalled result lost or changed");
	a_watch_flags: assert property (@(posedge clk) disable iff (!arst_n)
		watching_q == (jwatch_q || lwatch_q))
		else $error("watch flags disagree");
`endif

endmodule
